@@ rtl/core/jps_pkg.sv @@
`default_nettype none

package jps_pkg;

	localparam int MAX_TILE_LEN_DEF = 256;
	localparam int FRAC_BITS_DEF    = 24;

	localparam int VAL_W      = 32;
	localparam int TILE_LEN_W = 9;
	localparam int DOMAIN_W   = 16;
	localparam int AREA_W     = 31;
	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_LEN      = 3'd0,
		REG_DOMAIN_LEN    = 3'd1,
		REG_TILE_OFFSET_X = 3'd2,
		REG_TILE_OFFSET_Y = 3'd3,
		REG_STEP_AREA     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] cell_value;
		logic signed [VAL_W-1:0] source_term;
	} jps_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] new_value;
		logic                    last_of_sweep;
	} jps_out_t;

endpackage

`default_nettype wire

@@ rtl/core/jps_ram.sv @@
`default_nettype none

module jps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 258,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/jacobi_poisson_stencil_sweep.sv @@
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------------
// in       | in_valid / in_ready       | in_data  : cell_value, source_term
// out      | out_valid / out_ready     | out_data : new_value, last_of_sweep
// cfg      | cfg_we (write only)       | cfg_index, cfg_data
//
// One input transaction per clock unless out_ready stalls; results pass s1 to s3 and the
// output register. The rate is set by the line buffer RAMs, read at the acceptance edge.
// Reset clears the pipeline valids, the raster counters and one valid bit per line buffer
// column, so no clearing pass is needed; a column not yet written reads as zero.
// A stall on out_ready backs up through the three stages and output register to in_ready.

`default_nettype none

module jacobi_poisson_stencil_sweep #(
	parameter int MAX_TILE_LEN = jps_pkg::MAX_TILE_LEN_DEF,
	parameter int FRAC_BITS    = jps_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [jps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [jps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire jps_pkg::jps_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output jps_pkg::jps_out_t                   out_data
);

	import jps_pkg::*;

	localparam int DEPTH  = MAX_TILE_LEN + 2;
	localparam int AW     = $clog2(DEPTH);
	localparam int PAD_W  = $clog2(MAX_TILE_LEN + 3);
	localparam int CMP_W  = ((PAD_W > TILE_LEN_W) ? PAD_W : TILE_LEN_W) + 1;
	localparam int GX_W   = ((DOMAIN_W > AW) ? DOMAIN_W : AW) + 1;
	localparam int PROD_W = 2 * VAL_W;
	localparam int TW     = PROD_W - FRAC_BITS;
	localparam int NS_W   = VAL_W + 2;
	localparam int TOT_W  = TW + 2;
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	// configuration
	logic [TILE_LEN_W-1:0] tile_len_q;
	logic [DOMAIN_W-1:0]   domain_len_q;
	logic [DOMAIN_W-1:0]   offset_x_q;
	logic [DOMAIN_W-1:0]   offset_y_q;
	logic [AREA_W-1:0]     step_area_q;

	// raster position
	logic [AW-1:0]    col_q;
	logic [AW-1:0]    row_q;
	logic [CMP_W-1:0] len_ext;
	logic [CMP_W-1:0] len_cl;
	logic [PAD_W-1:0] len_eff;
	logic [PAD_W-1:0] pad;
	logic             out_of_range;
	logic [AW-1:0]    col_c;
	logic [AW-1:0]    row_c;
	logic [AW-1:0]    col_nb;
	logic [PAD_W-1:0] col_inc;
	logic [PAD_W-1:0] row_inc;
	logic [AW-1:0]    col_nx;
	logic [AW-1:0]    row_nx;
	logic             produce_c;
	logic             last_c;
	logic             accept;

	logic [DEPTH-1:0] vld_q;

	// stage 1
	logic                    v_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic [AW-1:0]           col_s1;
	logic [AW-1:0]           row_s1;
	logic                    produce_s1;
	logic                    last_s1;
	logic                    vc_s1;
	logic                    vn_s1;
	logic [VAL_W-1:0]        up_rd;
	logic [VAL_W-1:0]        mida_rd;
	logic [VAL_W-1:0]        midb_rd;
	logic [VAL_W-1:0]        src_rd;
	logic signed [VAL_W-1:0] up_v;
	logic signed [VAL_W-1:0] mid_v;
	logic signed [VAL_W-1:0] right_v;
	logic signed [VAL_W-1:0] src_v;
	logic signed [VAL_W-1:0] left_q;
	logic signed [NS_W-1:0]  nsum_c;
	logic signed [AREA_W:0]  area_c;
	logic signed [PROD_W-1:0] prod_c;
	logic [GX_W-1:0]         gx_c;
	logic [GX_W-1:0]         gy_c;
	logic [GX_W-1:0]         dl_last_c;
	logic                    edge_c;
	logic                    s1_leave;

	// stage 2
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [NS_W-1:0]   nsum_s2;
	logic                     edge_s2;
	logic signed [VAL_W-1:0]  src_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] rnd_c;
	logic signed [TW-1:0]     term_c;
	logic signed [TOT_W-1:0]  sum_c;

	// stage 3
	logic                    v_s3;
	logic signed [TOT_W-1:0] sum_s3;
	logic                    edge_s3;
	logic signed [VAL_W-1:0] src_s3;
	logic                    last_s3;
	logic signed [TOT_W-1:0] q_c;
	logic [TOT_W-VAL_W:0]    hi_c;
	logic signed [VAL_W-1:0] sat_c;
	logic signed [VAL_W-1:0] res_c;

	// output
	logic     out_valid_q;
	jps_out_t out_q;

	logic out_rdy;
	logic s3_rdy;
	logic s2_rdy;
	logic s1_rdy;

	assign out_rdy  = !out_valid_q || out_ready;
	assign s3_rdy   = !v_s3 || out_rdy;
	assign s2_rdy   = !v_s2 || s3_rdy;
	assign s1_rdy   = !v_s1 || s2_rdy;
	assign in_ready = s1_rdy;
	assign accept   = in_valid && in_ready;
	assign s1_leave = v_s1 && s2_rdy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_len_q   <= TILE_LEN_W'(16);
			domain_len_q <= DOMAIN_W'(16);
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			step_area_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILE_LEN:      tile_len_q   <= cfg_data[TILE_LEN_W-1:0];
				REG_DOMAIN_LEN:    domain_len_q <= cfg_data[DOMAIN_W-1:0];
				REG_TILE_OFFSET_X: offset_x_q   <= cfg_data[DOMAIN_W-1:0];
				REG_TILE_OFFSET_Y: offset_y_q   <= cfg_data[DOMAIN_W-1:0];
				REG_STEP_AREA:     step_area_q  <= cfg_data[AREA_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position of the incoming cell
	always_comb begin
		len_ext = CMP_W'(tile_len_q);
		if (len_ext == '0) begin
			len_cl = CMP_W'(1);
		end else if (len_ext > CMP_W'(MAX_TILE_LEN)) begin
			len_cl = CMP_W'(MAX_TILE_LEN);
		end else begin
			len_cl = len_ext;
		end
		len_eff = len_cl[PAD_W-1:0];
		pad     = len_eff + PAD_W'(2);

		out_of_range = (PAD_W'(col_q) >= pad) || (PAD_W'(row_q) >= pad);
		col_c = out_of_range ? '0 : col_q;
		row_c = out_of_range ? '0 : row_q;
		col_nb = (col_c == AW'(DEPTH - 1)) ? '0 : col_c + AW'(1);

		produce_c = (PAD_W'(row_c) >= PAD_W'(2)) && (col_c != '0)
			&& (PAD_W'(col_c) <= len_eff);
		last_c = (PAD_W'(row_c) == len_eff + PAD_W'(1)) && (PAD_W'(col_c) == len_eff);

		col_inc = PAD_W'(col_c) + PAD_W'(1);
		row_inc = PAD_W'(row_c) + PAD_W'(1);
		if (col_inc >= pad) begin
			col_nx = '0;
			row_nx = (row_inc >= pad) ? '0 : row_inc[AW-1:0];
		end else begin
			col_nx = col_inc[AW-1:0];
			row_nx = row_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			vld_q <= '0;
		end else if (accept) begin
			col_q        <= col_nx;
			row_q        <= row_nx;
			vld_q[col_c] <= 1'b1;
		end
	end

	// line buffers
	jps_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_upper (
		.clk   (clk),
		.we    (s1_leave),
		.waddr (col_s1),
		.wdata (mid_v),
		.re    (accept),
		.raddr (col_c),
		.rdata (up_rd)
	);

	jps_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_middle_a (
		.clk   (clk),
		.we    (accept),
		.waddr (col_c),
		.wdata (in_data.cell_value),
		.re    (accept),
		.raddr (col_c),
		.rdata (mida_rd)
	);

	jps_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_middle_b (
		.clk   (clk),
		.we    (accept),
		.waddr (col_c),
		.wdata (in_data.cell_value),
		.re    (accept),
		.raddr (col_nb),
		.rdata (midb_rd)
	);

	jps_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_source (
		.clk   (clk),
		.we    (accept),
		.waddr (col_c),
		.wdata (in_data.source_term),
		.re    (accept),
		.raddr (col_c),
		.rdata (src_rd)
	);

	// stage 1: window, product, edge test
	always_comb begin
		up_v    = vc_s1 ? signed'(up_rd) : '0;
		mid_v   = vc_s1 ? signed'(mida_rd) : '0;
		right_v = vn_s1 ? signed'(midb_rd) : '0;
		src_v   = vc_s1 ? signed'(src_rd) : '0;

		nsum_c = NS_W'(up_v) + NS_W'(right_v) + NS_W'(left_q) + NS_W'(val_s1);
		area_c = signed'({1'b0, step_area_q});
		prod_c = src_v * area_c;

		gx_c      = GX_W'(offset_x_q) + GX_W'(col_s1) - GX_W'(1);
		gy_c      = GX_W'(offset_y_q) + GX_W'(row_s1) - GX_W'(2);
		dl_last_c = GX_W'(domain_len_q) - GX_W'(1);
		edge_c = (gx_c == '0) || (gy_c == '0)
			|| ((domain_len_q != '0) && ((gx_c == dl_last_c) || (gy_c == dl_last_c)));
	end

	// stage 2: round product and add
	always_comb begin
		rnd_c  = prod_s2 + signed'(HALF);
		term_c = rnd_c[PROD_W-1:FRAC_BITS];
		sum_c  = TOT_W'(term_c) + TOT_W'(nsum_s2);
	end

	// stage 3: quarter with rounding, saturate, source term on an edge
	always_comb begin
		q_c  = (sum_s3 + TOT_W'(2)) >>> 2;
		hi_c = q_c[TOT_W-1:VAL_W-1];
		if (!q_c[TOT_W-1] && (|hi_c)) begin
			sat_c = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (q_c[TOT_W-1] && !(&hi_c)) begin
			sat_c = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat_c = q_c[VAL_W-1:0];
		end
		res_c = edge_s3 ? src_s3 : sat_c;
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_rdy) begin
				v_s1 <= accept;
			end
			if (s2_rdy) begin
				v_s2 <= v_s1 && produce_s1;
			end
			if (s3_rdy) begin
				v_s3 <= v_s2;
			end
			if (out_rdy) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1     <= in_data.cell_value;
			col_s1     <= col_c;
			row_s1     <= row_c;
			produce_s1 <= produce_c;
			last_s1    <= last_c;
			vc_s1      <= vld_q[col_c];
			vn_s1      <= vld_q[col_nb];
		end
		if (s1_leave) begin
			left_q  <= mid_v;
			prod_s2 <= prod_c;
			nsum_s2 <= nsum_c;
			edge_s2 <= edge_c;
			src_s2  <= src_v;
			last_s2 <= last_s1;
		end
		if (v_s2 && s3_rdy) begin
			sum_s3  <= sum_c;
			edge_s3 <= edge_s2;
			src_s3  <= src_s2;
			last_s3 <= last_s2;
		end
		if (v_s3 && out_rdy) begin
			out_q.new_value     <= res_c;
			out_q.last_of_sweep <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// line buffer read data must not be overwritten while stage 1 holds
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s2_rdy |-> !in_ready)
		else $error("transaction accepted while stage 1 is stalled");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		PAD_W'(col_q) <= PAD_W'(MAX_TILE_LEN + 1) && PAD_W'(row_q) <= PAD_W'(MAX_TILE_LEN + 1))
		else $error("raster counter beyond line buffer depth");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s3))
		else $error("result without a stage 3 transaction");

endmodule

`default_nettype wire

@@ verif/tb_jacobi_poisson_stencil_sweep.sv @@
module tb_jacobi_poisson_stencil_sweep;
	import jps_pkg::*;

	localparam int LINE_DEPTH    = MAX_TILE_LEN_DEF + 2;
	localparam int SETTLE_CYCLES = 10;
	localparam int CELL_GOAL     = 1100;
	localparam int CYCLE_LIMIT   = 250000;

	typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_PERIODIC} rx_mode_t;

	typedef struct {
		bit       is_cfg;
		cfg_reg_t reg_id;
		int unsigned wdata;
		jps_in_t  grid_in;
		bit       typed;
		jps_out_t want;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	jps_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	jps_out_t              out_data;

	jacobi_poisson_stencil_sweep dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the configuration registers
	bit [8:0]  sh_tile_len = 9'd16;
	bit [15:0] sh_domain_len = 16'd16;
	bit [15:0] sh_off_x;
	bit [15:0] sh_off_y;
	bit [30:0] sh_step_area;

	// shadow of the line buffers and raster position
	bit signed [31:0] upper_line [LINE_DEPTH];
	bit signed [31:0] middle_line [LINE_DEPTH];
	bit signed [31:0] middle_src [LINE_DEPTH];
	bit signed [31:0] left_value;
	int unsigned      col_pos;
	int unsigned      row_pos;

	jps_out_t    pending_updates[$];
	stim_row_t   stim_table[$];
	jps_out_t    head_update;
	int unsigned cells_sent;
	int unsigned updates_seen;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	bit          steady;

	function automatic bit is_domain_edge(input int unsigned g);
		return g == 0 || (sh_domain_len != 0 && g == int'(sh_domain_len) - 1);
	endfunction

	task automatic stencil_update(input jps_in_t grid_in, output bit hit, output jps_out_t upd);
		int unsigned      len, pad, c, r, gx, gy;
		bit signed [31:0] down, up, mid, csrc;
		longint           prod, sum, q;
		hit = 1'b0;
		upd = '0;
		len = sh_tile_len;
		if (len < 1) len = 1;
		if (len > MAX_TILE_LEN_DEF) len = MAX_TILE_LEN_DEF;
		pad = len + 2;
		if (col_pos >= pad || row_pos >= pad) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		down = grid_in.cell_value;
		up = upper_line[c];
		mid = middle_line[c];
		csrc = middle_src[c];
		if (r >= 2 && c >= 1 && c <= len) begin
			gx = sh_off_x + c - 1;
			gy = sh_off_y + r - 2;
			if (is_domain_edge(gx) || is_domain_edge(gy)) begin
				upd.new_value = csrc;
			end else begin
				prod = longint'(csrc) * longint'(sh_step_area);
				sum = longint'(up) + longint'(down) + longint'(left_value)
					+ longint'(middle_line[c + 1]) + ((prod + 64'sd8388608) >>> 24);
				q = (sum + 2) >>> 2;
				if (q > 64'sd2147483647) upd.new_value = 32'h7FFFFFFF;
				else if (q < -64'sd2147483648) upd.new_value = 32'h80000000;
				else upd.new_value = q[31:0];
			end
			upd.last_of_sweep = (r == len + 1 && c == len);
			hit = 1'b1;
		end
		upper_line[c] = mid;
		middle_line[c] = down;
		middle_src[c] = grid_in.source_term;
		left_value = mid;
		c++;
		if (c >= pad) begin
			c = 0;
			r++;
			if (r >= pad) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	task automatic write_reg(input cfg_reg_t id, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= id;
		cfg_data <= value[30:0];
		@(posedge clk);
		case (id)
			REG_TILE_LEN:      sh_tile_len = value[8:0];
			REG_DOMAIN_LEN:    sh_domain_len = value[15:0];
			REG_TILE_OFFSET_X: sh_off_x = value[15:0];
			REG_TILE_OFFSET_Y: sh_off_y = value[15:0];
			REG_STEP_AREA:     sh_step_area = value[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_cell(input jps_in_t grid_in, input bit typed, input jps_out_t want);
		bit          hit;
		jps_out_t    upd;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= grid_in;
		do @(posedge clk); while (!in_ready);
		stencil_update(grid_in, hit, upd);
		if (typed) pending_updates.push_back(want);
		else if (hit) pending_updates.push_back(upd);
		cells_sent++;
		burst_left--;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_cfg(input cfg_reg_t id, input int unsigned value);
		stim_row_t row;
		row = '{reg_id: id, default: '0};
		row.is_cfg = 1'b1;
		row.reg_id = id;
		row.wdata = value;
		stim_table.push_back(row);
	endtask

	task automatic add_cell(input logic [31:0] v, input logic [31:0] s, input bit typed,
			input logic [31:0] want_value);
		stim_row_t row;
		row = '{reg_id: REG_TILE_LEN, default: '0};
		row.grid_in.cell_value = v;
		row.grid_in.source_term = s;
		row.typed = typed;
		row.want.new_value = want_value;
		row.want.last_of_sweep = typed;
		stim_table.push_back(row);
	endtask

	function automatic logic [31:0] pick_q824();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 32'h07FFFFFF) - 32'h04000000;
		endcase
	endfunction

	function automatic int unsigned pick_offset(input int unsigned len);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return $urandom_range(0, 3);
			2: return (int'(sh_domain_len) - int'(len) - 1 + int'($urandom_range(0, 2))) & 16'hFFFF;
			3: return 16'hFFFF;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	initial begin
		int unsigned mode, span, tick;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (rx_mode_t'(mode))
					RX_OPEN:  out_ready <= 1'b1;
					RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
					RX_CHOKE: out_ready <= ($urandom_range(0, 7) == 0);
					default:  out_ready <= (tick % 11) < 6;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			updates_seen++;
			if (pending_updates.size() == 0) begin
				$display("%0t: unexpected transaction new_value %h last_of_sweep %b",
					$time, out_data.new_value, out_data.last_of_sweep);
				mismatch_count++;
			end else begin
				head_update = pending_updates.pop_front();
				if (out_data.new_value !== head_update.new_value) begin
					$display("%0t: new_value expected %h actual %h",
						$time, head_update.new_value, out_data.new_value);
					mismatch_count++;
				end
				if (out_data.last_of_sweep !== head_update.last_of_sweep) begin
					$display("%0t: last_of_sweep expected %b actual %b",
						$time, head_update.last_of_sweep, out_data.last_of_sweep);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, pending_updates.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int unsigned phase, tile, len, pad, n, dom;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3 padded tiles, one update per sweep on the eighth cell
		add_cfg(REG_TILE_LEN, 1);
		for (int i = 0; i < 9; i++)
			add_cell(i << 24, (i == 4) ? 32'h80000000 : 32'h0, i == 7, 32'h80000000);
		add_cfg(REG_TILE_OFFSET_X, 5);
		add_cfg(REG_TILE_OFFSET_Y, 5);
		add_cfg(REG_STEP_AREA, 32'h7FFFFFFF);
		for (int i = 0; i < 9; i++)
			add_cell(32'h7FFFFFFF, 32'h7FFFFFFF, i == 7, 32'h7FFFFFFF);
		for (int i = 0; i < 9; i++)
			add_cell(32'h80000000, 32'h80000000, i == 7, 32'h80000000);

		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg) begin
				settle();
				write_reg(stim_table[i].reg_id, stim_table[i].wdata);
			end else begin
				push_cell(stim_table[i].grid_in, stim_table[i].typed, stim_table[i].want);
			end
		end

		for (phase = 0; cells_sent < CELL_GOAL; phase++) begin
			settle();
			case (phase)
				1: tile = 0;
				3: tile = ($urandom_range(0, 1) != 0) ? 256 : 511;
				default: tile = ($urandom_range(0, 6) == 0) ? $urandom_range(7, 12)
					: $urandom_range(1, 6);
			endcase
			write_reg(REG_TILE_LEN, tile);
			len = (tile == 0) ? 1 : ((tile > MAX_TILE_LEN_DEF) ? MAX_TILE_LEN_DEF : tile);
			pad = len + 2;
			if (phase == 0 || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0: dom = 0;
					1: dom = 16'hFFFF;
					2: dom = $urandom_range(1, 2);
					3: dom = $urandom_range(0, 16'hFFFF);
					default: dom = $urandom_range(3, len + 4);
				endcase
				write_reg(REG_DOMAIN_LEN, dom);
			end
			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(REG_TILE_OFFSET_X, pick_offset(len));
			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(REG_TILE_OFFSET_Y, pick_offset(len));
			if (phase == 0 || $urandom_range(0, 1) != 0) begin
				case ($urandom_range(0, 4))
					0: write_reg(REG_STEP_AREA, 0);
					1: write_reg(REG_STEP_AREA, 32'h7FFFFFFF);
					2: write_reg(REG_STEP_AREA, 32'h01000000);
					3: write_reg(REG_STEP_AREA, $urandom & 32'h7FFFFFFF);
					default: write_reg(REG_STEP_AREA, $urandom_range(0, 32'h02000000));
				endcase
			end
			if (phase == 3) n = 2 * pad + 24;
			else n = ((len > 6) ? 1 : $urandom_range(1, 3)) * pad * pad
				+ (($urandom_range(0, 1) != 0) ? $urandom_range(1, pad * pad - 1) : 0);
			steady = ($urandom_range(0, 3) == 0);
			repeat (n) push_cell({pick_q824(), pick_q824()}, 1'b0, '0);
		end

		settle();
		$display("%0d cell transactions in, %0d updates checked, %0d register phases",
			cells_sent, updates_seen, phase);
		$display("tile sizes 0 to 511, domain edges, saturation and mid-sweep resizes covered");
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
